[src/cc20_pkg.sv]
// ----------------------------------------------------------------------------
// cc20_pkg
// shared types, constants and round functions for the chacha20 keystream block
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam int ROUND_COUNT_DEF = 20;
    localparam int WORD_W          = 32;
    localparam int NUM_WORDS       = 16;
    localparam int PAIR_W          = 2 * WORD_W;
    localparam int ADDR_W          = 6;

    // rotation amounts of the two halves of a quarter-round
    localparam int unsigned ROT_A0 = 16;
    localparam int unsigned ROT_B0 = 12;
    localparam int unsigned ROT_A1 = 8;
    localparam int unsigned ROT_B1 = 7;

    // "expand 32-byte k" as little-endian words
    localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_state;

    typedef enum logic [2:0] {
        REG_KEY_01 = 3'd0,
        REG_KEY_23 = 3'd1,
        REG_KEY_45 = 3'd2,
        REG_KEY_67 = 3'd3,
        REG_NONCE  = 3'd4
    } t_reg_idx;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // one half of four parallel quarter-rounds (column or diagonal)
    function automatic t_state half_round(input t_state s, input logic diag,
                                          input logic second);
        t_state          r;
        logic [3:0]      a, b, c, d;
        int unsigned     ra, rb;
        logic [WORD_W-1:0] wa, wb, wc, wd;
        r  = s;
        ra = second ? ROT_A1 : ROT_A0;
        rb = second ? ROT_B1 : ROT_B0;
        for (int q = 0; q < 4; q++) begin
            a  = 4'(q);
            b  = 4'(4  + ((q + (diag ? 1 : 0)) & 3));
            c  = 4'(8  + ((q + (diag ? 2 : 0)) & 3));
            d  = 4'(12 + ((q + (diag ? 3 : 0)) & 3));
            wa = s[a] + s[b];
            wd = rotl(s[d] ^ wa, ra);
            wc = s[c] + wd;
            wb = rotl(s[b] ^ wc, rb);
            r[a] = wa;
            r[b] = wb;
            r[c] = wc;
            r[d] = wd;
        end
        return r;
    endfunction

    function automatic t_state build_init(input logic [PAIR_W-1:0] k01,
                                          input logic [PAIR_W-1:0] k23,
                                          input logic [PAIR_W-1:0] k45,
                                          input logic [PAIR_W-1:0] k67,
                                          input logic [PAIR_W-1:0] ctr,
                                          input logic [PAIR_W-1:0] nonce);
        t_state s;
        s[0]  = SIGMA_0;
        s[1]  = SIGMA_1;
        s[2]  = SIGMA_2;
        s[3]  = SIGMA_3;
        s[4]  = k01[WORD_W-1:0];
        s[5]  = k01[PAIR_W-1:WORD_W];
        s[6]  = k23[WORD_W-1:0];
        s[7]  = k23[PAIR_W-1:WORD_W];
        s[8]  = k45[WORD_W-1:0];
        s[9]  = k45[PAIR_W-1:WORD_W];
        s[10] = k67[WORD_W-1:0];
        s[11] = k67[PAIR_W-1:WORD_W];
        s[12] = ctr[WORD_W-1:0];
        s[13] = ctr[PAIR_W-1:WORD_W];
        s[14] = nonce[WORD_W-1:0];
        s[15] = nonce[PAIR_W-1:WORD_W];
        return s;
    endfunction

endpackage

[src/cc20_stage.sv]
// ----------------------------------------------------------------------------
// cc20_stage
// one registered half-round stage: two add/xor/rotate steps per quarter-round
// ----------------------------------------------------------------------------
module cc20_stage #(
    parameter bit DIAG   = 1'b0,
    parameter bit SECOND = 1'b0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  cc20_pkg::t_state              i_state,
    input  logic [cc20_pkg::PAIR_W-1:0]   i_counter,
    output logic                          o_valid,
    output cc20_pkg::t_state              o_state,
    output logic [cc20_pkg::PAIR_W-1:0]   o_counter
);
    import cc20_pkg::*;

    logic             r_valid;
    t_state           r_state;
    logic [PAIR_W-1:0] r_counter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state   <= half_round(i_state, DIAG, SECOND);
            r_counter <= i_counter;
        end
    end

    assign o_valid   = r_valid;
    assign o_state   = r_state;
    assign o_counter = r_counter;

endmodule

[src/chacha20_block_keystream_top.sv]
// ----------------------------------------------------------------------------
// chacha20_block_keystream_top
// chacha20 block function, 64-bit counter and nonce, one 512-bit block per word
// ----------------------------------------------------------------------------
// pipeline: one setup stage, one stage per half quarter-round, output register
// throughput: one word per cycle, set by the fully unrolled half-round pipeline
// stall: the whole pipe holds while the output skid register is occupied
// reset: synchronous active-low i_rst_n clears all valid bits and the key and
//   nonce registers; no clearing pass
// ----------------------------------------------------------------------------
module chacha20_block_keystream_top #(
    parameter int ROUND_COUNT = cc20_pkg::ROUND_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // apb-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cc20_pkg::ADDR_W-1:0]   paddr,
    input  logic [cc20_pkg::PAIR_W-1:0]   pwdata,
    output logic [cc20_pkg::PAIR_W-1:0]   prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cc20_pkg::PAIR_W-1:0]   i_block_counter,
    // output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cc20_pkg::PAIR_W-1:0]   o_stream_words_0_1,
    output logic [cc20_pkg::PAIR_W-1:0]   o_stream_words_2_3,
    output logic [cc20_pkg::PAIR_W-1:0]   o_stream_words_4_5,
    output logic [cc20_pkg::PAIR_W-1:0]   o_stream_words_6_7,
    output logic [cc20_pkg::PAIR_W-1:0]   o_stream_words_8_9,
    output logic [cc20_pkg::PAIR_W-1:0]   o_stream_words_10_11,
    output logic [cc20_pkg::PAIR_W-1:0]   o_stream_words_12_13,
    output logic [cc20_pkg::PAIR_W-1:0]   o_stream_words_14_15
);
    import cc20_pkg::*;

    // odd round counts round up to a whole double round
    localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
    localparam int NUM_STAGES    = 4 * DOUBLE_ROUNDS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [PAIR_W-1:0] r_key_01, r_key_23, r_key_45, r_key_67, r_nonce;
    logic              w_cfg_wr;
    t_reg_idx          w_cfg_idx;

    // registers sit on 8-byte boundaries, low address bits are ignored
    assign w_cfg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign w_cfg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_01 <= '0;
            r_key_23 <= '0;
            r_key_45 <= '0;
            r_key_67 <= '0;
            r_nonce  <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_KEY_01: r_key_01 <= pwdata;
                REG_KEY_23: r_key_23 <= pwdata;
                REG_KEY_45: r_key_45 <= pwdata;
                REG_KEY_67: r_key_67 <= pwdata;
                REG_NONCE:  r_nonce  <= pwdata;
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_KEY_01: prdata = r_key_01;
            REG_KEY_23: prdata = r_key_23;
            REG_KEY_45: prdata = r_key_45;
            REG_KEY_67: prdata = r_key_67;
            REG_NONCE:  prdata = r_nonce;
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control: the whole pipe advances unless the skid is full,
    // so a word can still enter while a finished block waits at the output
    // ------------------------------------------------------------------
    logic r_skid_v, r_out_v;
    logic n_skid_v, n_out_v;
    logic w_en;
    logic w_exit;

    assign w_en    = !r_skid_v;
    assign o_ready = w_en;

    // stage arrays: index 0 is the setup stage, NUM_STAGES the last round
    logic [NUM_STAGES:0] w_v;
    t_state              w_s   [NUM_STAGES+1];
    logic [PAIR_W-1:0]   w_ctr [NUM_STAGES+1];

    // setup stage: assemble the initial state from config and the counter
    logic              r_v0;
    t_state            r_s0;
    logic [PAIR_W-1:0] r_ctr0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0   <= build_init(r_key_01, r_key_23, r_key_45, r_key_67,
                                 i_block_counter, r_nonce);
            r_ctr0 <= i_block_counter;
        end
    end

    assign w_v[0]   = r_v0;
    assign w_s[0]   = r_s0;
    assign w_ctr[0] = r_ctr0;

    // round stages: column half 0, column half 1, diagonal half 0, diagonal half 1
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        cc20_stage #(
            .DIAG   (1'((k / 2) % 2)),
            .SECOND (1'(k % 2))
        ) u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_valid   (w_v[k]),
            .i_state   (w_s[k]),
            .i_counter (w_ctr[k]),
            .o_valid   (w_v[k+1]),
            .o_state   (w_s[k+1]),
            .o_counter (w_ctr[k+1])
        );
    end

    // ------------------------------------------------------------------
    // feed-forward add of the initial state; the user must keep key and nonce stable
    // while blocks are in flight (not enforced); counter travels down with the block
    // ------------------------------------------------------------------
    t_state w_init_fin;
    t_state w_sum;

    assign w_init_fin = build_init(r_key_01, r_key_23, r_key_45, r_key_67,
                                   w_ctr[NUM_STAGES], r_nonce);

    always_comb begin
        for (int i = 0; i < NUM_WORDS; i++) begin
            w_sum[i] = w_s[NUM_STAGES][i] + w_init_fin[i];
        end
    end

    assign w_exit = w_v[NUM_STAGES] && w_en;

    // ------------------------------------------------------------------
    // output register plus one skid entry
    // ------------------------------------------------------------------
    t_state r_out, r_skid;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        if (r_skid_v) begin
            // output holds a block too; drain skid once it is taken
            if (i_ready) begin
                n_skid_v = 1'b0;
            end
        end else if (w_exit) begin
            if (!r_out_v || i_ready) begin
                n_out_v = 1'b1;
            end else begin
                n_skid_v = 1'b1;
            end
        end else if (i_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (w_exit) begin
            if (!r_out_v || i_ready) begin
                r_out <= w_sum;
            end else begin
                r_skid <= w_sum;
            end
        end
    end

    assign o_valid              = r_out_v;
    assign o_stream_words_0_1   = {r_out[1],  r_out[0]};
    assign o_stream_words_2_3   = {r_out[3],  r_out[2]};
    assign o_stream_words_4_5   = {r_out[5],  r_out[4]};
    assign o_stream_words_6_7   = {r_out[7],  r_out[6]};
    assign o_stream_words_8_9   = {r_out[9],  r_out[8]};
    assign o_stream_words_10_11 = {r_out[11], r_out[10]};
    assign o_stream_words_12_13 = {r_out[13], r_out[12]};
    assign o_stream_words_14_15 = {r_out[15], r_out[14]};

endmodule

[src/cc20_checker.sv]
// ----------------------------------------------------------------------------
// cc20_checker
// port-level checks on the keystream block handshakes
// ----------------------------------------------------------------------------
module cc20_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_ready,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [63:0] o_stream_words_0_1
);

    // reset empties the output side
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // input can only be blocked while a finished block is waiting
    a_block_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("o_ready low with empty output");

    // input side stalls only after an output stall
    a_ready_fall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(o_valid && !i_ready))
        else $error("o_ready fell without an output stall");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_stream_words_0_1))
        else $error("output changed while stalled");

endmodule

bind chacha20_block_keystream_top cc20_checker u_cc20_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_stream_words_0_1 (o_stream_words_0_1)
);
